/* rtl/roulette_draw_without_replacement_assert.svh */
// assertion macros used by the roulette draw datapath
`ifndef ROULETTE_DRAW_WITHOUT_REPLACEMENT_ASSERT_SVH
`define ROULETTE_DRAW_WITHOUT_REPLACEMENT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define RDW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdw check failed");

// next-cycle implication, off while reset is low
`define RDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdw check failed");

`endif

/* rtl/rdw_pkg.sv */
package rdw_pkg;

    localparam int RDW_POOL_DEPTH  = 64;
    localparam int RDW_WEIGHT_BITS = 16;

    localparam int IDX_BITS     = 6;
    localparam int VAL_BITS     = 16;
    localparam int RAND_BITS    = 16;
    localparam int STAT_BITS    = 2;
    localparam int PICK_BITS    = 7;
    localparam int CFG_BITS     = 7;
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 8;
    localparam int ADDR_BITS    = 3;

    // result status codes
    localparam logic [STAT_BITS-1:0] STAT_LOADED = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_DRAWN  = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY  = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_POOL_SIZE = 1'b0;

    // microprogram step addresses
    typedef logic [2:0] step_t;
    localparam step_t ST_CLR     = 3'd0;
    localparam step_t ST_IDLE    = 3'd1;
    localparam step_t ST_LD_RD   = 3'd2;
    localparam step_t ST_LD_WR   = 3'd3;
    localparam step_t ST_DR_INIT = 3'd4;
    localparam step_t ST_DR_WALK = 3'd5;
    localparam step_t ST_DR_END  = 3'd6;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_DISPATCH = 3'd2,
        J_CLR      = 3'd3,
        J_WALK     = 3'd4
    } jmp_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_CLR  = 2'd1,
        CNT_INC  = 2'd2
    } cnt_op_t;

    typedef enum logic [2:0] {
        MEM_NONE    = 3'd0,
        MEM_CLR     = 3'd1,
        MEM_RD_IDX  = 3'd2,
        MEM_RD_CNT  = 3'd3,
        MEM_RD_NEXT = 3'd4,
        MEM_WR_LOAD = 3'd5,
        MEM_WR_PICK = 3'd6
    } mem_op_t;

    typedef enum logic [1:0] {
        TOT_HOLD = 2'd0,
        TOT_LOAD = 2'd1,
        TOT_DRAW = 2'd2
    } tot_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_LOAD = 2'd1,
        EMIT_DRAW = 2'd2
    } emit_t;

    // one control word
    typedef struct packed {
        logic    ready;
        jmp_t    jmp;
        step_t   target;
        cnt_op_t cnt;
        mem_op_t mem;
        logic    thr_ld;
        logic    scan;
        tot_op_t tot;
        emit_t   emit;
    } uword_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic req_draw;
        logic clr_end;
        logic walk_end;
        logic stall;
    } seq_stat_t;

    // microprogram rom
    function automatic uword_t urom_word(input step_t a);
        uword_t w;
        begin
            w = '0;
            case (a)
                ST_CLR: begin
                    w.mem = MEM_CLR;
                    w.cnt = CNT_INC;
                    w.jmp = J_CLR;
                end
                ST_IDLE: begin
                    w.ready  = 1'b1;
                    w.cnt    = CNT_CLR;
                    w.jmp    = J_DISPATCH;
                    w.target = ST_DR_INIT;
                end
                ST_LD_RD: begin
                    w.mem = MEM_RD_IDX;
                    w.jmp = J_NEXT;
                end
                ST_LD_WR: begin
                    w.mem    = MEM_WR_LOAD;
                    w.tot    = TOT_LOAD;
                    w.emit   = EMIT_LOAD;
                    w.jmp    = J_GOTO;
                    w.target = ST_IDLE;
                end
                ST_DR_INIT: begin
                    w.mem    = MEM_RD_CNT;
                    w.thr_ld = 1'b1;
                    w.jmp    = J_NEXT;
                end
                ST_DR_WALK: begin
                    w.mem  = MEM_RD_NEXT;
                    w.scan = 1'b1;
                    w.cnt  = CNT_INC;
                    w.jmp  = J_WALK;
                end
                ST_DR_END: begin
                    w.mem    = MEM_WR_PICK;
                    w.tot    = TOT_DRAW;
                    w.emit   = EMIT_DRAW;
                    w.jmp    = J_GOTO;
                    w.target = ST_IDLE;
                end
                default: begin
                    w.jmp    = J_GOTO;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/rdw_mem.sv */
module rdw_mem
    import rdw_pkg::*;
#(
    parameter int DEPTH = RDW_POOL_DEPTH,
    parameter int WIDTH = RDW_WEIGHT_BITS,
    parameter int AW    = $clog2(RDW_POOL_DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rdw_seq.sv */
module rdw_seq
    import rdw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_stat_t stat,
    output uword_t    ctrl
);

    step_t upc_reg;
    step_t upc_next;

    assign ctrl = urom_word(upc_reg);

    always_comb begin
        upc_next = upc_reg;
        case (ctrl.jmp)
            J_NEXT:     upc_next = upc_reg + 3'd1;
            J_GOTO:     upc_next = ctrl.target;
            J_DISPATCH: begin
                if (stat.accept) begin
                    upc_next = stat.req_draw ? ctrl.target : upc_reg + 3'd1;
                end
            end
            J_CLR:      upc_next = stat.clr_end ? upc_reg + 3'd1 : upc_reg;
            J_WALK:     upc_next = stat.walk_end ? upc_reg + 3'd1 : upc_reg;
            default:    upc_next = ST_IDLE;
        endcase
        // result steps hold while the output register is still full
        if (stat.stall) begin
            upc_next = upc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_CLR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/rdw_dpath.sv */
`include "roulette_draw_without_replacement_assert.svh"

module rdw_dpath
    import rdw_pkg::*;
#(
    parameter int POOL_DEPTH  = RDW_POOL_DEPTH,
    parameter int WEIGHT_BITS = RDW_WEIGHT_BITS,
    parameter int AW          = $clog2(RDW_POOL_DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  uword_t                  ctrl,
    output seq_stat_t               stat,
    input  logic [AW-1:0]           pool_last,
    input  logic                    s_tvalid,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic [0:0]              s_tuser,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic [STAT_BITS-1:0]    m_tuser,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [WEIGHT_BITS-1:0]  mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  logic [WEIGHT_BITS-1:0]  mem_rdata
);

    localparam int TOTW = WEIGHT_BITS + AW;
    localparam int THRW = TOTW + RAND_BITS;
    localparam int IW   = (AW > IDX_BITS) ? AW : IDX_BITS;
    localparam int AW1  = AW + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(POOL_DEPTH - 1);

    logic [AW-1:0]          cnt_reg;
    logic [IDX_BITS-1:0]    ld_idx_reg;
    logic [WEIGHT_BITS-1:0] ld_w_reg;
    logic [RAND_BITS-1:0]   r_reg;
    logic [TOTW-1:0]        total_reg;
    logic [THRW-1:0]        thr_reg;
    logic [TOTW-1:0]        cum_reg;
    logic                   any_reg;
    logic                   found_reg;
    logic [AW-1:0]          pick_reg;
    logic [WEIGHT_BITS-1:0] pick_w_reg;
    logic [AW-1:0]          last_reg;
    logic [WEIGHT_BITS-1:0] last_w_reg;
    logic                   m_tvalid_reg;
    logic [STAT_BITS-1:0]   m_stat_reg;
    logic [PICK_BITS-1:0]   m_pick_reg;

    logic                   accept;
    logic                   stall;
    logic                   idx_ok;
    logic [IW-1:0]          idx_wide;
    logic [AW-1:0]          ld_addr;
    logic                   w_nz;
    logic [TOTW-1:0]        cum_sum;
    logic                   hit;
    logic [AW-1:0]          sel;
    logic [WEIGHT_BITS-1:0] sel_w;

    assign accept   = s_tvalid && ctrl.ready;
    assign stall    = (ctrl.emit != EMIT_NONE) && m_tvalid_reg && !m_tready;

    assign stat.accept   = accept;
    assign stat.req_draw = s_tuser[0];
    assign stat.clr_end  = (cnt_reg == CLR_LAST);
    assign stat.walk_end = (cnt_reg == pool_last);
    assign stat.stall    = stall;

    // load address, entries past the store depth are dropped
    assign idx_ok   = (32'(ld_idx_reg) < POOL_DEPTH);
    assign idx_wide = IW'(ld_idx_reg);
    assign ld_addr  = idx_wide[AW-1:0];

    // one entry of the walk
    assign w_nz    = (mem_rdata != '0);
    assign cum_sum = cum_reg + TOTW'(mem_rdata);
    assign hit     = w_nz && !found_reg && ({cum_sum, {RAND_BITS{1'b0}}} >= thr_reg);

    // threshold never met falls back to the last nonzero entry
    assign sel   = found_reg ? pick_reg : last_reg;
    assign sel_w = found_reg ? pick_w_reg : last_w_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cnt_reg;
        case (ctrl.mem)
            MEM_CLR:     mem_we = 1'b1;
            MEM_RD_IDX: begin
                mem_re    = 1'b1;
                mem_raddr = ld_addr;
            end
            MEM_RD_CNT:  mem_re = 1'b1;
            MEM_RD_NEXT: begin
                mem_re    = 1'b1;
                mem_raddr = cnt_reg + AW'(1);
            end
            MEM_WR_LOAD: begin
                mem_we    = idx_ok && !stall;
                mem_waddr = ld_addr;
                mem_wdata = ld_w_reg;
            end
            MEM_WR_PICK: begin
                mem_we    = any_reg && !stall;
                mem_waddr = sel;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            total_reg    <= '0;
            any_reg      <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (ctrl.cnt)
                CNT_CLR: cnt_reg <= '0;
                CNT_INC: cnt_reg <= cnt_reg + AW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
            if (ctrl.thr_ld) begin
                any_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            if (ctrl.scan && w_nz) begin
                any_reg <= 1'b1;
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
            if (!stall) begin
                if (ctrl.tot == TOT_LOAD && idx_ok) begin
                    total_reg <= total_reg - TOTW'(mem_rdata) + TOTW'(ld_w_reg);
                end else if (ctrl.tot == TOT_DRAW && any_reg) begin
                    total_reg <= total_reg - TOTW'(sel_w);
                end
            end
            if (ctrl.emit != EMIT_NONE && !stall) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ld_idx_reg <= s_tdata[IDX_BITS-1:0];
            ld_w_reg   <= WEIGHT_BITS'(s_tdata[IDX_BITS +: VAL_BITS]);
            r_reg      <= s_tdata[IDX_BITS+VAL_BITS +: RAND_BITS];
        end
        if (ctrl.thr_ld) begin
            thr_reg <= THRW'(r_reg) * THRW'(total_reg);
            cum_reg <= '0;
        end
        if (ctrl.scan && w_nz) begin
            cum_reg    <= cum_sum;
            last_reg   <= cnt_reg;
            last_w_reg <= mem_rdata;
            if (hit) begin
                pick_reg   <= cnt_reg;
                pick_w_reg <= mem_rdata;
            end
        end
        if (!stall) begin
            if (ctrl.emit == EMIT_LOAD) begin
                m_stat_reg <= STAT_LOADED;
                m_pick_reg <= '0;
            end else if (ctrl.emit == EMIT_DRAW) begin
                m_stat_reg <= any_reg ? STAT_DRAWN : STAT_EMPTY;
                m_pick_reg <= any_reg ? PICK_BITS'(AW1'(sel) + AW1'(1)) : '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_pick_reg);
    assign m_tuser  = m_stat_reg;

    `RDW_ASSERT_SAME(a_pick_nonzero, aclk, aresetn, ctrl.emit == EMIT_DRAW && !stall && any_reg, sel_w != '0)
    `RDW_ASSERT_SAME(a_cum_in_total, aclk, aresetn, ctrl.scan, cum_reg <= total_reg)
    `RDW_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, accept, !accept)
    `RDW_ASSERT_SAME(a_drawn_index, aclk, aresetn, m_tvalid_reg && m_stat_reg == STAT_DRAWN, m_pick_reg != '0)

endmodule

/* rtl/roulette_draw_without_replacement.sv */
// channel   dir  handshake                   payload
// s_        in   s_tvalid / s_tready         s_tuser: req type; s_tdata: index, weight, fraction
// m_        out  m_tvalid / m_tready         m_tuser: status; m_tdata: picked index
// apb       in   psel, penable, pwrite       pool size at byte address 0
//
// a load beat runs through accept, read of the old weight, write-back and total update
// a draw beat runs through accept, threshold multiply, a walk over the clamped pool size,
// one stored weight per cycle through the single memory read port, zeroing write-back
// after reset a clearing pass writes every one of the POOL_DEPTH entries, one a cycle,
// and s_tready stays low until that pass is done
// a finished result sits in the output register; the next beat is taken meanwhile and
// only the step that posts a result waits for m_tready
module roulette_draw_without_replacement
    import rdw_pkg::*;
#(
    parameter int POOL_DEPTH  = RDW_POOL_DEPTH,
    parameter int WEIGHT_BITS = RDW_WEIGHT_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input beats
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // entry_index, weight_value, random_fraction
    input  logic [0:0]              s_tuser,   // req_type
    // result beats
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // picked_index
    output logic [STAT_BITS-1:0]    m_tuser,   // status
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_BITS-1:0]    paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW = $clog2(POOL_DEPTH);
    // reset pool size is 64, cut down to the pool depth
    localparam int POOL_RST = (POOL_DEPTH < 64) ? POOL_DEPTH : 64;
    localparam logic [AW-1:0] POOL_LAST_RST = AW'(POOL_RST - 1);

    uword_t                 ctrl;
    seq_stat_t              stat;
    logic [AW-1:0]          pool_last_reg;
    logic [AW-1:0]          pool_last_next;
    logic [CFG_BITS-1:0]    cfg_val;
    logic                   cfg_wr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [WEIGHT_BITS-1:0] mem_rdata;

    // apb: writes land in the access phase, pool size kept as last walked entry
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);
    assign cfg_val = pwdata[CFG_BITS-1:0];

    always_comb begin
        // zero acts as one, anything past the store as the whole store
        if (cfg_val == '0) begin
            pool_last_next = '0;
        end else if (32'(cfg_val) > POOL_DEPTH) begin
            pool_last_next = AW'(POOL_DEPTH - 1);
        end else begin
            pool_last_next = AW'(cfg_val - CFG_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_last_reg <= POOL_LAST_RST;
        end else if (cfg_wr) begin
            pool_last_reg <= pool_last_next;
        end
    end

    assign prdata = (paddr[2] == REG_POOL_SIZE) ? 32'(pool_last_reg) + 32'd1 : 32'd0;

    // sequencer owns the program counter, ready comes from the idle step
    assign s_tready = ctrl.ready;

    rdw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    rdw_dpath #(
        .POOL_DEPTH  (POOL_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS),
        .AW          (AW)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .pool_last (pool_last_reg),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // weight store, single write and single registered read port
    rdw_mem #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (WEIGHT_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rdw_pkg::*;

    // request kinds carried on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    localparam int RANDOM_ITEMS = 1150;

    // one input beat, split into its fields
    typedef struct packed {
        logic                 req;
        logic [IDX_BITS-1:0]  idx;
        logic [VAL_BITS-1:0]  weight;
        logic [RAND_BITS-1:0] frac;
    } req_item_t;

    // one result beat
    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [PICK_BITS-1:0] pick;
    } result_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;   // entry_index, weight_value, random_fraction
    logic [0:0]              s_tuser  = '0;   // req_type
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;         // picked_index
    logic [STAT_BITS-1:0]    m_tuser;         // status
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]    paddr    = '0;
    logic [31:0]             pwdata   = '0;
    logic [31:0]             prdata;
    logic                    pready;

    roulette_draw_without_replacement uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // beats waiting to be sent, and results the pool model says must come back
    req_item_t pending_reqs[$];
    result_t   awaited_results[$];

    // shadow of the pool: weights, their total and the pool size register
    logic [VAL_BITS-1:0] weight_mem [RDW_POOL_DEPTH];
    logic [21:0]         weight_sum = '0;
    logic [CFG_BITS-1:0] pool_cfg   = CFG_BITS'(64);

    logic in_beat_done = 1'b0;   // input beat taken at the last rising edge
    logic calm         = 1'b0;   // no idling on either side while set
    int   fail_count   = 0;
    int   queued       = 0;
    int   loads_seen   = 0;
    int   draws_made   = 0;
    int   empties_seen = 0;
    int   settings_run = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // generous fixed limit: far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("timeout: %0d results still awaited", awaited_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // effective pool size: zero acts as one, anything above the depth as the depth
    function automatic int unsigned active_span(input logic [CFG_BITS-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > RDW_POOL_DEPTH)
            return RDW_POOL_DEPTH;
        return 32'(cfg);
    endfunction

    // works out the result of one beat and updates the shadow pool
    task automatic roulette_predict(input req_item_t it, output result_t res);
        int unsigned span;
        int unsigned pick;
        int unsigned last_nz;
        logic [21:0] run_sum;
        logic [37:0] thresh;
        logic        hit;
        logic        seen;
        span    = active_span(pool_cfg);
        pick    = 0;
        last_nz = 0;
        run_sum = '0;
        hit     = 1'b0;
        seen    = 1'b0;
        res.status = STAT_LOADED;
        res.pick   = '0;
        if (it.req == REQ_LOAD) begin
            weight_sum = weight_sum - 22'(weight_mem[it.idx]) + 22'(it.weight);
            weight_mem[it.idx] = it.weight;
        end else begin
            // compare cumulative weight scaled by 2^16 against r times the total
            thresh = 38'(it.frac) * 38'(weight_sum);
            for (int unsigned j = 0; j < span; j++) begin
                if (weight_mem[IDX_BITS'(j)] != 0) begin
                    seen    = 1'b1;
                    last_nz = j;
                    run_sum = run_sum + 22'(weight_mem[IDX_BITS'(j)]);
                    if (!hit && {run_sum, 16'h0000} >= thresh) begin
                        hit  = 1'b1;
                        pick = j;
                    end
                end
            end
            if (!seen) begin
                res.status = STAT_EMPTY;
            end else begin
                // threshold never met when weight sits outside the active range
                if (!hit)
                    pick = last_nz;
                weight_sum                     = weight_sum - 22'(weight_mem[IDX_BITS'(pick)]);
                weight_mem[IDX_BITS'(pick)]    = '0;
                res.status                     = STAT_DRAWN;
                res.pick                       = PICK_BITS'(pick + 1);
            end
        end
    endtask

    // driver: a fresh beat once the previous one is taken, with random gaps
    always @(negedge aclk) begin : drive_requests
        req_item_t nxt;
        if (aresetn && (!s_tvalid || in_beat_done)) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.req;
                s_tdata  <= {2'b00, nxt.frac, nxt.weight, nxt.idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    // monitor: check result beats in order, predict each accepted input beat
    always @(posedge aclk) begin : watch_beats
        result_t   want;
        result_t   got;
        req_item_t taken;
        if (!aresetn) begin
            in_beat_done <= 1'b0;
        end else begin
            in_beat_done <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing awaited: status %0d, picked_index %0d",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== M_TDATA_BITS'(want.pick)) begin
                        $error("picked_index: expected %0d, got %0d", want.pick, m_tdata);
                        fail_count++;
                    end
                    case (want.status)
                        STAT_LOADED: loads_seen++;
                        STAT_DRAWN:  draws_made++;
                        default:     empties_seen++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                taken.req    = s_tuser[0];
                taken.idx    = s_tdata[5:0];
                taken.weight = s_tdata[21:6];
                taken.frac   = s_tdata[37:22];
                roulette_predict(taken, got);
                awaited_results.push_back(got);
            end
        end
    end

    task automatic queue_load(input int unsigned idx, input int unsigned w);
        req_item_t it;
        it.req    = REQ_LOAD;
        it.idx    = IDX_BITS'(idx);
        it.weight = VAL_BITS'(w);
        it.frac   = RAND_BITS'($urandom);   // ignored by a load
        pending_reqs.push_back(it);
        queued++;
    endtask

    task automatic queue_draw(input int unsigned r);
        req_item_t it;
        it.req    = REQ_DRAW;
        it.idx    = IDX_BITS'($urandom);    // ignored by a draw
        it.weight = VAL_BITS'($urandom);
        it.frac   = RAND_BITS'(r);
        pending_reqs.push_back(it);
        queued++;
    endtask

    // hold off until every queued beat is sent and every result is back
    task automatic drain();
        @(posedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // apb write of the pool size: setup cycle, then access cycle
    task automatic write_pool_size(input int unsigned v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POOL_SIZE, 2'b00};
        pwdata  <= 32'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        pool_cfg  = CFG_BITS'(v);
        settings_run++;
    endtask

    // weights lean towards the corners: zero, small values, full scale
    function automatic int unsigned pick_weight();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(1, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned pick_fraction();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned sizes [6];
        int unsigned sz;
        int unsigned span;
        int unsigned nfill;
        int unsigned ndraw;
        int          phase;
        sizes = '{1, 64, 0, 127, 65, 2};
        for (int k = 0; k < RDW_POOL_DEPTH; k++)
            weight_mem[IDX_BITS'(k)] = '0;

        // reset held low, then released on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        write_pool_size(64);
        queue_draw(16'h1234);          // nothing loaded yet: empty pool
        queue_load(0, 16'hFFFF);       // full-scale weights at both ends
        queue_load(63, 16'hFFFF);
        queue_load(5, 0);              // zero weight is never picked
        queue_load(10, 1);
        queue_draw(0);                 // r of zero must skip zero entries
        queue_draw(16'hFFFF);          // largest fraction
        queue_draw(16'h8000);
        queue_draw(0);                 // all drawn: empty again
        queue_load(20, 16'hFFFF);
        queue_load(20, 7);             // overwrite adjusts the total
        queue_draw(16'hFFFF);
        drain();

        // weight left outside the active range: walk ends short, last nonzero taken
        write_pool_size(4);
        queue_load(2, 100);
        queue_load(40, 16'hFFFF);
        queue_draw(16'hFFFF);
        queue_draw(16'h4000);          // only the out-of-range entry remains
        drain();

        // zero register value acts as a single entry
        write_pool_size(0);
        queue_load(0, 9);
        queue_draw(16'hFFFF);
        queue_draw(0);
        drain();

        // value above the depth acts as the full depth
        write_pool_size(127);
        queue_draw(16'hFFFF);
        drain();

        // ---- random part ----
        queued = 0;
        phase  = 0;
        while (queued < RANDOM_ITEMS) begin
            sz = (phase < 6) ? sizes[3'(phase)]
                 : (($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(1, 64));
            write_pool_size(sz);
            span = active_span(CFG_BITS'(sz));
            // a long stretch with no idling on either side
            calm = (phase == 3 || phase == 4);
            if (phase % 5 == 4) begin
                // noise: loads and draws in any order
                repeat (40) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_load($urandom_range(0, 63), pick_weight());
                    else
                        queue_draw(pick_fraction());
                end
            end else begin
                // fill a set of entries, mostly in the active range, then draw it dry
                nfill = $urandom_range(1, (span < 24) ? span + 2 : 24);
                repeat (nfill) begin
                    if ($urandom_range(0, 9) < 8)
                        queue_load($urandom_range(0, span - 1), pick_weight());
                    else
                        queue_load($urandom_range(0, 63), pick_weight());
                end
                ndraw = nfill + $urandom_range(0, 3);
                repeat (ndraw) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_load($urandom_range(0, span - 1), pick_weight());
                    queue_draw(pick_fraction());
                end
            end
            // sender pauses here until every result is back
            drain();
            calm = 1'b0;
            phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count++;
        end

        $display("run covered %0d loads, %0d draws and %0d empty-pool replies",
                 loads_seen, draws_made, empties_seen);
        $display("across %0d pool size settings including zero, one and above the depth",
                 settings_run);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
